// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: rtl/mvc_pkg.sv
// Types and constants for the mesh volume and centroid block.
package mvc_pkg;

    localparam int SUM_W     = 64;
    localparam int CENTER_W  = 20;
    localparam int QUOT_W    = CENTER_W + 3;
    localparam int IN_LANE_W = 12;
    localparam int MIN_W     = 40;

    localparam logic [CENTER_W-1:0] CENTER_POS_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
    localparam logic [CENTER_W-1:0] CENTER_NEG_MAG = {1'b1, {(CENTER_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    // Multiply sequence, one multiplication issued per step before S_END.
    typedef enum logic [4:0] {
        S_NX_P, S_NX_M, S_NY_P, S_NY_M, S_NZ_P, S_NZ_M,
        S_VX, S_VY, S_VZ,
        S_SQX0, S_SQX1, S_SQX2,
        S_SQY0, S_SQY1, S_SQY2,
        S_SQZ0, S_SQZ1, S_SQZ2,
        S_MX, S_MY, S_MZ,
        S_END
    } step_t;

endpackage

// File: rtl/mvc_div.sv
// Bit-serial restoring divider for one centroid axis, with saturation.
module mvc_div
    import mvc_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                neg,
    input  logic [SUM_W-1:0]    mag,
    input  logic [SUM_W-1:0]    divisor,
    output logic                done,
    output logic [CENTER_W-1:0] center
);

    localparam int DW  = SUM_W + FRACTION_BITS;
    localparam int CNW = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]    sh_reg, sh_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic             big_reg, big_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] d_reg, d_next;

    logic [SUM_W:0]   rem_sh;
    logic             ge;
    logic [CENTER_W-1:0] qs;
    logic [CENTER_W-1:0] cmag;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        big_next  = big_reg;
        neg_next  = neg_reg;
        d_next    = d_reg;
        rem_sh    = {rem_reg[SUM_W-1:0], sh_reg[DW-1]};
        ge        = (rem_sh >= {1'b0, d_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(DW);
            sh_next   = DW'(mag) << FRACTION_BITS;
            rem_next  = '0;
            q_next    = '0;
            big_next  = 1'b0;
            neg_next  = neg;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 1;
            rem_next = ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            big_next = big_reg | q_reg[QUOT_W-1];
            q_next   = {q_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        big_reg <= big_next;
        neg_reg <= neg_next;
        d_reg   <= d_next;
    end

    // Drop the factor of 8, then clamp to the signed output range.
    always_comb
    begin
        qs = q_reg[QUOT_W-1:3];
        if (neg_reg)
        begin
            cmag   = (big_reg || qs > CENTER_NEG_MAG) ? CENTER_NEG_MAG : qs;
            center = CENTER_W'(0) - cmag;
        end
        else
        begin
            cmag   = (big_reg || qs > CENTER_POS_MAX) ? CENTER_POS_MAX : qs;
            center = cmag;
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/mesh_volume_centroid.sv
// Mesh volume and centroid: top level with multiply sequencer and accumulators.
// Usage:
//   s_* channel: one triangle per transaction, tdata holds a_x..c_z (12 bits
//   each, a_x lowest), tlast marks the final triangle of a mesh.
//   m_* channel: one result per mesh, tdata holds six_volume, center_x/y/z,
//   tuser holds center_valid and overflowed.
//   cfg_wr_en/cfg_wr_data write min_six_volume; write only while idle.
// Operation:
//   Each triangle runs 21 multiplications through one shared 29x29 multiplier,
//   one per cycle, and the last product is written back before the next
//   triangle is accepted. On the final triangle three bit-serial divisions
//   follow one after another (skipped when the volume is at or below the
//   threshold), before the result is loaded into the output register.
// Reset clears the four running sums, the overflow flag, the threshold and the output valid flag.
// The result waits in the output register; the next mesh may start meanwhile,
// but its result is held back until the previous one is taken.
module mesh_volume_centroid
    import mvc_pkg::*;
#(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [MIN_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [111:0]       s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, pad
    input  logic               s_tlast,   // last_triangle
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,   // six_volume, center_x, center_y, center_z
    output logic [1:0]         m_tuser    // center_valid, overflowed
);

    localparam int C   = COORD_BITS;
    localparam int DFW = C + 1;
    localparam int NW  = 2 * C + 3;
    localparam int SQW = 2 * C + 4;
    localparam int MW  = 2 * C + 5;
    localparam int PW  = 2 * MW;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    step_t  wb_step_reg;
    logic   wb_vld_reg;
    logic [1:0] axis_reg, axis_next;

    logic signed [C-1:0]   va_reg [3];
    logic signed [C-1:0]   vb_reg [3];
    logic signed [C-1:0]   vc_reg [3];
    logic                  last_reg;
    logic signed [DFW-1:0] d1 [3];
    logic signed [DFW-1:0] d2 [3];
    logic signed [DFW-1:0] sab [3];
    logic signed [DFW-1:0] sbc [3];
    logic signed [DFW-1:0] sca [3];

    logic signed [NW-1:0]    n_reg [3];
    logic        [SQW-1:0]   sq_reg [3];
    logic signed [SUM_W-1:0] vt_reg;
    logic signed [SUM_W-1:0] vol_reg;
    logic signed [SUM_W-1:0] mom_reg [3];
    logic                    ovf_reg;
    logic [MIN_W-1:0]        min_reg;

    logic signed [MW-1:0] opa, opb;
    logic signed [PW-1:0] p_reg;
    logic signed [SUM_W-1:0] p64;

    logic signed [SUM_W-1:0] sat_acc, sat_t, sat_res;
    logic signed [SUM_W:0]   sat_sum;
    logic                    sat_ovf;

    logic [CENTER_W-1:0] cen_reg [3];
    logic                cval_reg;

    logic                m_tvalid_reg;
    logic [127:0]        m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic accept_in, issue, vol_ok, load_out, clear_sums;
    logic div_start, div_done;
    logic [CENTER_W-1:0] div_center;
    logic signed [SUM_W-1:0] div_num;
    logic [SUM_W-1:0] div_mag;

    assign accept_in = s_tvalid && s_tready;
    assign vol_ok    = vol_reg > $signed({{(SUM_W-MIN_W){1'b0}}, min_reg});

    // Edge vectors and pair sums of the held triangle.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k]  = DFW'(vb_reg[k]) - DFW'(va_reg[k]);
            d2[k]  = DFW'(vc_reg[k]) - DFW'(va_reg[k]);
            sab[k] = DFW'(va_reg[k]) + DFW'(vb_reg[k]);
            sbc[k] = DFW'(vb_reg[k]) + DFW'(vc_reg[k]);
            sca[k] = DFW'(vc_reg[k]) + DFW'(va_reg[k]);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept_in)
                    state_next = ST_MAC;
            ST_MAC:
                if (step_reg == S_END)
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
            ST_CHECK:
                state_next = vol_ok ? ST_DIV : ST_OUT;
            ST_DIV:
                if (div_done && axis_reg == 2'd2)
                    state_next = ST_OUT;
            ST_OUT:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_tready   = 1'b0;
        issue      = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        step_next  = step_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                step_next = S_NX_P;
            end
            ST_MAC:
            begin
                issue = (step_reg != S_END);
                if (step_reg != S_END)
                    step_next = step_t'(step_reg + 1'b1);
            end
            ST_CHECK:
            begin
                div_start = vol_ok;
                axis_next = 2'd0;
            end
            ST_DIV:
                if (div_done)
                begin
                    axis_next = axis_reg + 1'b1;
                    div_start = (axis_reg != 2'd2);
                end
            ST_OUT:
                load_out = !m_tvalid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    assign clear_sums = load_out;

    // Operand select for the shared multiplier.
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (step_reg)
            S_NX_P: begin opa = MW'(d1[1]); opb = MW'(d2[2]); end
            S_NX_M: begin opa = MW'(d1[2]); opb = MW'(d2[1]); end
            S_NY_P: begin opa = MW'(d1[2]); opb = MW'(d2[0]); end
            S_NY_M: begin opa = MW'(d1[0]); opb = MW'(d2[2]); end
            S_NZ_P: begin opa = MW'(d1[0]); opb = MW'(d2[1]); end
            S_NZ_M: begin opa = MW'(d1[1]); opb = MW'(d2[0]); end
            S_VX:   begin opa = MW'(va_reg[0]); opb = MW'(n_reg[0]); end
            S_VY:   begin opa = MW'(va_reg[1]); opb = MW'(n_reg[1]); end
            S_VZ:   begin opa = MW'(va_reg[2]); opb = MW'(n_reg[2]); end
            S_SQX0: begin opa = MW'(sab[0]); opb = MW'(sab[0]); end
            S_SQX1: begin opa = MW'(sbc[0]); opb = MW'(sbc[0]); end
            S_SQX2: begin opa = MW'(sca[0]); opb = MW'(sca[0]); end
            S_SQY0: begin opa = MW'(sab[1]); opb = MW'(sab[1]); end
            S_SQY1: begin opa = MW'(sbc[1]); opb = MW'(sbc[1]); end
            S_SQY2: begin opa = MW'(sca[1]); opb = MW'(sca[1]); end
            S_SQZ0: begin opa = MW'(sab[2]); opb = MW'(sab[2]); end
            S_SQZ1: begin opa = MW'(sbc[2]); opb = MW'(sbc[2]); end
            S_SQZ2: begin opa = MW'(sca[2]); opb = MW'(sca[2]); end
            S_MX:   begin opa = MW'(n_reg[0]); opb = $signed({1'b0, sq_reg[0]}); end
            S_MY:   begin opa = MW'(n_reg[1]); opb = $signed({1'b0, sq_reg[1]}); end
            S_MZ:   begin opa = MW'(n_reg[2]); opb = $signed({1'b0, sq_reg[2]}); end
            default:
            begin
            end
        endcase
    end

    assign p64 = SUM_W'(p_reg);

    // Shared saturating adder for the four running sums.
    always_comb
    begin
        sat_acc = vol_reg;
        sat_t   = vt_reg;
        case (wb_step_reg)
            S_MX: begin sat_acc = mom_reg[0]; sat_t = p64; end
            S_MY: begin sat_acc = mom_reg[1]; sat_t = p64; end
            S_MZ: begin sat_acc = mom_reg[2]; sat_t = p64; end
            default:
            begin
            end
        endcase
        sat_sum = {sat_acc[SUM_W-1], sat_acc} + {sat_t[SUM_W-1], sat_t};
        sat_ovf = sat_sum[SUM_W] != sat_sum[SUM_W-1];
        if (!sat_ovf)
            sat_res = sat_sum[SUM_W-1:0];
        else if (sat_sum[SUM_W])
            sat_res = {1'b1, {(SUM_W-1){1'b0}}};
        else
            sat_res = {1'b0, {(SUM_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= S_NX_P;
            wb_step_reg  <= S_NX_P;
            wb_vld_reg   <= 1'b0;
            axis_reg     <= 2'd0;
            min_reg      <= '0;
            vol_reg      <= '0;
            mom_reg[0]   <= '0;
            mom_reg[1]   <= '0;
            mom_reg[2]   <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            axis_reg    <= axis_next;
            wb_vld_reg  <= issue;
            if (issue)
                wb_step_reg <= step_reg;
            if (cfg_wr_en)
                min_reg <= cfg_wr_data;
            if (clear_sums)
            begin
                vol_reg    <= '0;
                mom_reg[0] <= '0;
                mom_reg[1] <= '0;
                mom_reg[2] <= '0;
                ovf_reg    <= 1'b0;
            end
            else if (wb_vld_reg)
            begin
                case (wb_step_reg)
                    S_SQX0: begin vol_reg <= sat_res;    ovf_reg <= ovf_reg | sat_ovf; end
                    S_MX:   begin mom_reg[0] <= sat_res; ovf_reg <= ovf_reg | sat_ovf; end
                    S_MY:   begin mom_reg[1] <= sat_res; ovf_reg <= ovf_reg | sat_ovf; end
                    S_MZ:   begin mom_reg[2] <= sat_res; ovf_reg <= ovf_reg | sat_ovf; end
                    default:
                    begin
                    end
                endcase
            end
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            for (int k = 0; k < 3; k++)
            begin
                va_reg[k] <= s_tdata[k*IN_LANE_W +: C];
                vb_reg[k] <= s_tdata[(3+k)*IN_LANE_W +: C];
                vc_reg[k] <= s_tdata[(6+k)*IN_LANE_W +: C];
            end
            last_reg <= s_tlast;
        end
        p_reg <= opa * opb;
        if (wb_vld_reg)
        begin
            case (wb_step_reg)
                S_NX_P: n_reg[0] <= NW'(p_reg);
                S_NX_M: n_reg[0] <= n_reg[0] - NW'(p_reg);
                S_NY_P: n_reg[1] <= NW'(p_reg);
                S_NY_M: n_reg[1] <= n_reg[1] - NW'(p_reg);
                S_NZ_P: n_reg[2] <= NW'(p_reg);
                S_NZ_M: n_reg[2] <= n_reg[2] - NW'(p_reg);
                S_VX:   vt_reg <= p64;
                S_VY:   vt_reg <= vt_reg + p64;
                S_VZ:   vt_reg <= vt_reg + p64;
                S_SQX0: sq_reg[0] <= SQW'(p_reg);
                S_SQX1: sq_reg[0] <= sq_reg[0] + SQW'(p_reg);
                S_SQX2: sq_reg[0] <= sq_reg[0] + SQW'(p_reg);
                S_SQY0: sq_reg[1] <= SQW'(p_reg);
                S_SQY1: sq_reg[1] <= sq_reg[1] + SQW'(p_reg);
                S_SQY2: sq_reg[1] <= sq_reg[1] + SQW'(p_reg);
                S_SQZ0: sq_reg[2] <= SQW'(p_reg);
                S_SQZ1: sq_reg[2] <= sq_reg[2] + SQW'(p_reg);
                S_SQZ2: sq_reg[2] <= sq_reg[2] + SQW'(p_reg);
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_CHECK)
        begin
            cval_reg   <= vol_ok;
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
        end
        if (state_reg == ST_DIV && div_done)
            cen_reg[axis_reg] <= div_center;
        if (load_out)
        begin
            m_tdata_reg <= {4'd0, cen_reg[2], cen_reg[1], cen_reg[0], vol_reg};
            m_tuser_reg <= {ovf_reg, cval_reg};
        end
    end

    // Numerator for the division that starts this cycle.
    assign div_num = (state_reg == ST_CHECK) ? mom_reg[0] :
                     (axis_reg == 2'd0) ? mom_reg[1] : mom_reg[2];
    assign div_mag = div_num[SUM_W-1] ? (SUM_W'(0) - div_num) : div_num;

    mvc_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .neg     (div_num[SUM_W-1]),
        .mag     (div_mag),
        .divisor (vol_reg),
        .done    (div_done),
        .center  (div_center)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/mvc_checker.sv
// Port-level checker for the mesh volume and centroid block, with its bind.
`include "assert_macros.svh"

module mvc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "ready right after accept")
    `ASSERT_CLK(a_zero_center, clk, rst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata[127:64] == 64'd0), "center nonzero without valid volume")
    `ASSERT_CLK(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind mesh_volume_centroid mvc_checker u_mvc_checker (.*);
